[rtl/drks_pkg.sv]
// shared widths, record type and defaults for the draw record key sorter
package drks_pkg;

  localparam int unsigned DIST_W          = 31;
  localparam int unsigned STATE_W         = 48;
  localparam int unsigned HANDLE_W        = 32;
  localparam int unsigned MAX_RECORDS_DEF = 64;

  // field order gives the sort order: distance, then state, then handle
  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [STATE_W-1:0]  state;
    logic [HANDLE_W-1:0] handle;
  } rec_t;

endpackage

[rtl/draw_record_key_sort_top.sv]
// draw record batch sorter: insertion sort on load, ordered read-out on the last record
//
// Records come in on the input channel (in_valid/in_ready) and are kept in a
// single-port-write, single-port-read store of MAX_RECORDS entries, already in
// ascending order: each new record walks down from the top of the batch, one
// comparison and one shifted entry per cycle through the shared comparator.
// A record that lands on top is written at its first comparison; one that moves to
// the bottom is compared with every record already held, then written in S_PLACE.
// in_ready is high only while the block is idle between records.
// A record that arrives with the store full is dropped and marks the batch
// as overflowed; every result of that batch then carries overflow = 1.
// The request marked is_last starts the read-out on the output channel
// (out_valid/out_ready): each entry goes through the registered read port
// (S_RD, or a prefetch in S_WAIT) before the output register (S_LD), and
// out_valid drops when a result is taken and rises once the next is loaded.
// A stalled receiver just holds the output register; nothing is lost.
// After the result marked last_out is taken the block is empty and ready.
// Reset (rst, synchronous) empties the store and clears the overflow mark.
module draw_record_key_sort_top #(
  parameter int unsigned MAX_RECORDS = drks_pkg::MAX_RECORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [drks_pkg::DIST_W-1:0]   dist_key,
  input  logic [drks_pkg::STATE_W-1:0]  state_key,
  input  logic [drks_pkg::HANDLE_W-1:0] surf_handle,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [drks_pkg::DIST_W-1:0]   out_dist_key,
  output logic [drks_pkg::STATE_W-1:0]  out_state_key,
  output logic [drks_pkg::HANDLE_W-1:0] out_surf_handle,
  output logic                          last_out,
  output logic                          overflow
);
  import drks_pkg::*;

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_RD,
    S_LD,
    S_WAIT
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic            dropped;
  logic [AW-1:0]   j;
  logic [AW-1:0]   k;
  rec_t            nrec;
  logic            nlast;

  rec_t            mem [MAX_RECORDS];
  rec_t            rdata;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;
  logic [AW-1:0]   rd_addr;
  logic            greater;
  logic            full;

  assign in_ready = (state == S_IDLE);
  assign greater  = (rdata > nrec);
  assign full     = (count == CW'(MAX_RECORDS));

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j;
    wr_data = nrec;
    rd_addr = j - AW'(2);
    case (state)
      S_IDLE: begin
        rd_addr = count[AW-1:0] - AW'(1);
      end
      S_CMP: begin
        wr_en   = 1'b1;
        wr_data = greater ? rdata : nrec;
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      S_RD: begin
        rd_addr = k;
      end
      S_WAIT: begin
        // prefetch the next entry while the current result waits
        rd_addr = k + AW'(1);
      end
      default: begin
        rd_addr = k;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            nrec.distance <= dist_key;
            nrec.state    <= state_key;
            nrec.handle   <= surf_handle;
            nlast         <= is_last;
            j             <= count[AW-1:0];
            if (full) begin
              dropped <= 1'b1;
              if (is_last) begin
                k     <= '0;
                state <= S_RD;
              end
            end else if (count == '0) begin
              state <= S_PLACE;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (greater) begin
            // shift the larger entry up one slot and keep walking down
            j <= j - AW'(1);
            if (j == AW'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            count <= count + CW'(1);
            k     <= '0;
            state <= nlast ? S_RD : S_IDLE;
          end
        end
        S_PLACE: begin
          count <= count + CW'(1);
          k     <= '0;
          state <= nlast ? S_RD : S_IDLE;
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          out_dist_key    <= rdata.distance;
          out_state_key   <= rdata.state;
          out_surf_handle <= rdata.handle;
          last_out        <= (CW'(k) + CW'(1) == count);
          overflow        <= dropped;
          out_valid       <= 1'b1;
          state           <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_out) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= S_LD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/drks_check.sv]
// port-level checks for the draw record key sorter, bound to the top level
module drks_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [drks_pkg::DIST_W-1:0]   dist_key,
  input logic [drks_pkg::STATE_W-1:0]  state_key,
  input logic [drks_pkg::HANDLE_W-1:0] surf_handle,
  input logic                          is_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [drks_pkg::DIST_W-1:0]   out_dist_key,
  input logic [drks_pkg::STATE_W-1:0]  out_state_key,
  input logic [drks_pkg::HANDLE_W-1:0] out_surf_handle,
  input logic                          last_out,
  input logic                          overflow
);

  // the input is not ready while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while results are pending");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a taken result that is not the last keeps the input closed
  a_more_results: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_out) |=> !in_ready)
    else $error("input reopened before the batch was fully read out");

  // once the last result is taken the block is empty and ready again
  a_batch_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_out) |=> (in_ready && !out_valid))
    else $error("block not idle after the last result");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_dist_key)
      && $stable(out_state_key) && $stable(out_surf_handle)
      && $stable(last_out) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind draw_record_key_sort_top drks_check u_drks_check (.*);
